### hdl/pdsc_pkg.sv
// ----------------------------------------------------------------------------
// pdsc_pkg
// Types, character constants and class-history helpers for the path
// dot-segment checker.
// ----------------------------------------------------------------------------
package pdsc_pkg;

  // character class of one decoded code point
  typedef enum logic [1:0] {
    CLS_SLASH = 2'd0,
    CLS_DOT   = 2'd1,
    CLS_OTHER = 2'd2
  } char_class_t;

  // sticky reject flag plus the two most recent classes
  typedef struct packed {
    logic        rej;
    char_class_t older;
    char_class_t newer;
  } class_hist_t;

  localparam int unsigned AccumW = 32;

  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContTag   = 8'h80;
  localparam logic [7:0] LeadMin   = 8'hC0;

  localparam logic [AccumW-1:0] CodeSlash  = AccumW'(32'h2F);
  localparam logic [AccumW-1:0] CodeBslash = AccumW'(32'h5C);
  localparam logic [AccumW-1:0] CodeDot    = AccumW'(32'h2E);

  localparam class_hist_t HistReset = '{rej: 1'b0, older: CLS_SLASH, newer: CLS_SLASH};

  // map a code point to its class, backslash counts as slash
  function automatic char_class_t classify(input logic [AccumW-1:0] v);
    char_class_t c;
    if (v == CodeSlash || v == CodeBslash) begin
      c = CLS_SLASH;
    end else if (v == CodeDot) begin
      c = CLS_DOT;
    end else begin
      c = CLS_OTHER;
    end
    return c;
  endfunction

  // shift one class into the history, flag "/./" and "/.."
  function automatic class_hist_t push_class(input class_hist_t h, input char_class_t c);
    class_hist_t r;
    r = h;
    if (h.older == CLS_SLASH && h.newer == CLS_DOT && (c == CLS_SLASH || c == CLS_DOT)) begin
      r.rej = 1'b1;
    end
    r.older = h.newer;
    r.newer = c;
    return r;
  endfunction

  // dropped sequence: lead plus taken continuations all count as other
  function automatic class_hist_t flush_other(input class_hist_t h, input logic [2:0] taken);
    class_hist_t r;
    r = h;
    if (taken == 3'd0) begin
      r.older = h.newer;
    end else begin
      r.older = CLS_OTHER;
    end
    r.newer = CLS_OTHER;
    return r;
  endfunction

endpackage

### hdl/path_dot_segment_checker_top.sv
// ----------------------------------------------------------------------------
// path_dot_segment_checker_top
// Streams a path one byte per transaction, decodes UTF-8 (overlong forms
// included) and returns one verdict on the last transaction of each path.
// ----------------------------------------------------------------------------
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid in_ready in_path_byte in_byte_present |  input
//          | in_path_end                                    |
//  out     | out_valid out_ready out_reasonable             |  output
//
//  one byte per cycle; decode and class update are a single combinational
//  pass from the input ports into the state and result registers
//  a verdict appears in the cycle after the path_end transaction
//  in_ready drops only while a verdict is held and out_ready is low
//  rst_n (synchronous) clears decoder state and the result register
// ----------------------------------------------------------------------------
module path_dot_segment_checker_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_path_byte,
  input  logic       in_byte_present,
  input  logic       in_path_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_reasonable
);
  import pdsc_pkg::*;

  class_hist_t       hist_r, hist_nxt;
  logic [2:0]        seq_rem_r, seq_rem_nxt;
  logic [2:0]        seq_taken_r, seq_taken_nxt;
  logic [AccumW-1:0] accum_r, accum_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_reasonable_r, out_reasonable_nxt;
  logic              in_acc;

  assign in_ready       = !out_valid_r || out_ready;
  assign in_acc         = in_valid && in_ready;
  assign out_valid      = out_valid_r;
  assign out_reasonable = out_reasonable_r;

  // byte decode, class history and end check
  always_comb begin
    class_hist_t       h;
    logic [2:0]        rem;
    logic [2:0]        taken;
    logic [AccumW-1:0] acc;
    h     = hist_r;
    rem   = seq_rem_r;
    taken = seq_taken_r;
    acc   = accum_r;
    out_reasonable_nxt = out_reasonable_r;
    out_valid_nxt      = out_valid_r && !out_ready;

    if (in_acc) begin
      if (in_byte_present) begin
        if (rem != 3'd0 && (in_path_byte & ContMask) == ContTag) begin
          // continuation byte extends the pending sequence
          acc   = {acc[AccumW-7:0], in_path_byte[5:0]};
          taken = taken + 3'd1;
          rem   = rem - 3'd1;
          if (rem == 3'd0) begin
            h     = push_class(h, classify(acc));
            acc   = '0;
            taken = 3'd0;
          end
        end else begin
          // broken sequence, then the byte starts fresh
          if (rem != 3'd0) begin
            h     = flush_other(h, taken);
            rem   = 3'd0;
            taken = 3'd0;
            acc   = '0;
          end
          if (in_path_byte >= LeadMin) begin
            taken = 3'd0;
            case (in_path_byte) inside
              [8'hC0:8'hDF]: begin
                rem = 3'd1;
                acc = AccumW'(in_path_byte[4:0]);
              end
              [8'hE0:8'hEF]: begin
                rem = 3'd2;
                acc = AccumW'(in_path_byte[3:0]);
              end
              [8'hF0:8'hF7]: begin
                rem = 3'd3;
                acc = AccumW'(in_path_byte[2:0]);
              end
              [8'hF8:8'hFB]: begin
                rem = 3'd4;
                acc = AccumW'(in_path_byte[1:0]);
              end
              default: begin
                rem = 3'd5;
                acc = AccumW'(in_path_byte[1:0]);
              end
            endcase
          end else begin
            h = push_class(h, classify(AccumW'(in_path_byte)));
          end
        end
      end

      if (in_path_end) begin
        // cut-off sequence counts as other, then trailing "/." check
        if (rem != 3'd0) begin
          h = flush_other(h, taken);
        end
        if (h.older == CLS_SLASH && h.newer == CLS_DOT) begin
          h.rej = 1'b1;
        end
        out_valid_nxt      = 1'b1;
        out_reasonable_nxt = !h.rej;
        h     = HistReset;
        rem   = 3'd0;
        taken = 3'd0;
        acc   = '0;
      end
    end

    hist_nxt      = h;
    seq_rem_nxt   = rem;
    seq_taken_nxt = taken;
    accum_nxt     = acc;
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r           <= HistReset;
      seq_rem_r        <= 3'd0;
      seq_taken_r      <= 3'd0;
      accum_r          <= '0;
      out_valid_r      <= 1'b0;
      out_reasonable_r <= 1'b0;
    end else begin
      hist_r           <= hist_nxt;
      seq_rem_r        <= seq_rem_nxt;
      seq_taken_r      <= seq_taken_nxt;
      accum_r          <= accum_nxt;
      out_valid_r      <= out_valid_nxt;
      out_reasonable_r <= out_reasonable_nxt;
    end
  end

  // no pending sequence means no taken continuations
  a_taken_idle: assert property (@(posedge clk) disable iff (!rst_n)
    seq_rem_r == 3'd0 |-> seq_taken_r == 3'd0)
    else $error("continuation count set with no pending sequence");

  // a sequence never spans more than five continuations
  a_seq_len: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, seq_rem_r} + {1'b0, seq_taken_r}) <= 4'd5)
    else $error("sequence length out of range");

  // a path end always leaves a verdict behind
  a_end_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_path_end |=> out_valid_r)
    else $error("path end produced no verdict");

  // decoder is back at its reset state after a path end
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_path_end |=> !hist_r.rej && seq_rem_r == 3'd0 && accum_r == '0)
    else $error("state not cleared after path end");

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the path dot-segment checker. Paths stream in one
// byte per transaction with random sender gaps and receiver stalls. A
// scoreboard tracks the UTF-8 decoder and the slash/dot class history on its
// own and checks every verdict in order. Stimulus starts with hand-picked
// paths and then builds random paths from slashes, dots, encoded forms,
// broken and cut-off sequences and noise bytes.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pdsc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ItemTarget = 1050;
  localparam int unsigned CalmAfter  = 900;

  // verdict predictor and in-order result check
  class path_verdict_board;
    logic        verdict_q[$];
    int          errors;
    logic        rej;
    char_class_t older_cls;
    char_class_t newer_cls;
    logic [2:0]  seq_left;
    logic [2:0]  seq_got;
    logic [35:0] code;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      rej       = 1'b0;
      older_cls = CLS_SLASH;
      newer_cls = CLS_SLASH;
      seq_left  = 3'd0;
      seq_got   = 3'd0;
      code      = '0;
    endfunction

    function char_class_t class_of(input logic [35:0] v);
      if (v == 36'h2F || v == 36'h5C) return CLS_SLASH;
      if (v == 36'h2E) return CLS_DOT;
      return CLS_OTHER;
    endfunction

    // slash then dot followed by slash or dot is a dot segment
    function void shift_in(input char_class_t c);
      if (older_cls == CLS_SLASH && newer_cls == CLS_DOT &&
          (c == CLS_SLASH || c == CLS_DOT)) rej = 1'b1;
      older_cls = newer_cls;
      newer_cls = c;
    endfunction

    // abandoned sequence: lead and each continuation count as other
    function void drop_seq();
      if (seq_left == 3'd0) return;
      for (int i = 0; i <= int'(seq_got); i++) shift_in(CLS_OTHER);
      seq_left = 3'd0;
      seq_got  = 3'd0;
      code     = '0;
    endfunction

    function void note_input(input logic [7:0] b, input logic pres, input logic last);
      if (pres) begin
        if (seq_left != 3'd0 && b[7:6] == 2'b10) begin
          code = {code[29:0], b[5:0]};
          seq_got++;
          seq_left--;
          if (seq_left == 3'd0) begin
            shift_in(class_of(code));
            code    = '0;
            seq_got = 3'd0;
          end
        end else begin
          drop_seq();
          if (b >= 8'hC0) begin
            // lead byte: length and payload bits from the prefix
            seq_got = 3'd0;
            if (b >= 8'hF8) begin
              seq_left = (b >= 8'hFC) ? 3'd5 : 3'd4;
              code     = 36'(b[1:0]);
            end else if (b >= 8'hF0) begin
              seq_left = 3'd3;
              code     = 36'(b[2:0]);
            end else if (b >= 8'hE0) begin
              seq_left = 3'd2;
              code     = 36'(b[3:0]);
            end else begin
              seq_left = 3'd1;
              code     = 36'(b[4:0]);
            end
          end else begin
            shift_in(class_of(36'(b)));
          end
        end
      end
      if (last) begin
        drop_seq();
        if (older_cls == CLS_SLASH && newer_cls == CLS_DOT) rej = 1'b1;
        verdict_q.push_back(!rej);
        clear();
      end
    endfunction

    task report(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(input logic got);
      logic want;
      if (verdict_q.size() == 0) begin
        report($sformatf("verdict %b with none expected", got));
      end else begin
        want = verdict_q.pop_front();
        if (got !== want) report($sformatf("reasonable %b, expected %b", got, want));
      end
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_path_byte;
  logic       in_byte_present;
  logic       in_path_end;
  logic       out_valid;
  logic       out_ready;
  logic       out_reasonable;

  path_verdict_board sb;
  int unsigned       items_sent;
  int unsigned       cycles;
  logic              calm;

  path_dot_segment_checker_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_path_byte    (in_path_byte),
    .in_byte_present (in_byte_present),
    .in_path_end     (in_path_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_reasonable  (out_reasonable)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // monitor both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_path_byte, in_byte_present, in_path_end);
      if (out_valid && out_ready) sb.check_result(out_reasonable);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("path_dot_segment_checker_top: mismatch");
      $finish;
    end
  end

  // result channel back-pressure in bursts
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end
  end

  // one input transaction, called at a falling edge, returns at a falling edge
  task automatic drive_item(input logic [7:0] b, input logic pres, input logic last);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_path_byte    <= b;
    in_byte_present <= pres;
    in_path_end     <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (pres || last) items_sent++;
    if (items_sent >= CalmAfter) calm = 1'b1;
    @(negedge clk);
  endtask

  // random path built from tokens
  task automatic emit_path(input int ntok);
    logic [7:0] bytes[$];
    logic [7:0] lo_lead[5];
    logic [7:0] hi_lead[5];
    logic [7:0] v;
    int         kind;
    int         k;
    int         j;
    logic       sep_end;
    lo_lead = '{8'hC0, 8'hE0, 8'hF0, 8'hF8, 8'hFC};
    hi_lead = '{8'hDF, 8'hEF, 8'hF7, 8'hFB, 8'hFF};
    for (int t = 0; t < ntok; t++) begin
      kind = $urandom_range(0, 99);
      k    = $urandom_range(1, 5);
      if (kind < 28) begin
        bytes.push_back($urandom_range(0, 2) == 0 ? 8'h5C : 8'h2F);
      end else if (kind < 48) begin
        bytes.push_back(8'h2E);
      end else if (kind < 62) begin
        bytes.push_back(8'($urandom_range(0, 8'h7F)));
      end else if (kind < 78) begin
        // overlong encoding of a slash, backslash or dot
        case ($urandom_range(0, 2))
          0:       v = 8'h2F;
          1:       v = 8'h5C;
          default: v = 8'h2E;
        endcase
        bytes.push_back(lo_lead[k-1] | 8'(v >> (6 * k)));
        for (int i = k - 1; i >= 0; i--) bytes.push_back(8'h80 | ((v >> (6 * i)) & 8'h3F));
      end else if (kind < 86) begin
        // complete sequence with random payload
        bytes.push_back(8'($urandom_range(lo_lead[k-1], hi_lead[k-1])));
        for (int i = 0; i < k; i++) bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else if (kind < 93) begin
        // sequence broken or cut off by whatever comes next
        j = $urandom_range(0, k - 1);
        bytes.push_back(8'($urandom_range(lo_lead[k-1], hi_lead[k-1])));
        for (int i = 0; i < j; i++) bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else begin
        bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    sep_end = (bytes.size() == 0) || ($urandom_range(0, 4) == 0);
    foreach (bytes[i]) begin
      if ($urandom_range(0, 19) == 0) drive_item(8'($urandom), 1'b0, 1'b0);
      drive_item(bytes[i], 1'b1, (i == bytes.size() - 1) && !sep_end);
    end
    if (sep_end) drive_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // main sequence
  initial begin
    sb              = new();
    items_sent      = 0;
    cycles          = 0;
    calm            = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_path_byte    = 8'h00;
    in_byte_present = 1'b0;
    in_path_end     = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty path
    drive_item(8'hFF, 1'b0, 1'b1);
    // lone dot ends in a slash-dot
    drive_item(8'h2E, 1'b1, 1'b1);
    // backslash, overlong dot, slash
    drive_item(8'h5C, 1'b1, 1'b0);
    drive_item(8'hC0, 1'b1, 1'b0);
    drive_item(8'hAE, 1'b1, 1'b0);
    drive_item(8'h2F, 1'b1, 1'b1);
    // six-byte dot then three-byte dot
    drive_item(8'hFC, 1'b1, 1'b0);
    drive_item(8'h80, 1'b1, 1'b0);
    drive_item(8'h80, 1'b1, 1'b0);
    drive_item(8'h80, 1'b1, 1'b0);
    drive_item(8'h80, 1'b1, 1'b0);
    drive_item(8'hAE, 1'b1, 1'b0);
    drive_item(8'hE0, 1'b1, 1'b0);
    drive_item(8'h80, 1'b1, 1'b0);
    drive_item(8'hAE, 1'b1, 1'b1);
    // lead broken by a dot
    drive_item(8'hC0, 1'b1, 1'b0);
    drive_item(8'h2E, 1'b1, 1'b1);
    // stray continuation, ignored item, plain bytes, cut-off sequence
    drive_item(8'h80, 1'b1, 1'b0);
    drive_item(8'h55, 1'b0, 1'b0);
    drive_item(8'h00, 1'b1, 1'b0);
    drive_item(8'h7F, 1'b1, 1'b0);
    drive_item(8'hE0, 1'b1, 1'b0);
    drive_item(8'h80, 1'b1, 1'b1);

    // random paths, mostly short
    while (items_sent < ItemTarget) begin
      emit_path($urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : $urandom_range(1, 10));
    end
    in_valid <= 1'b0;

    // drain and let the pipeline settle
    while (sb.verdict_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (sb.errors == 0) begin
      $display("path_dot_segment_checker_top: match");
    end else begin
      $display("path_dot_segment_checker_top: mismatch");
    end
    $finish;
  end

endmodule

### path_dot_segment_checker_top.f
hdl/pdsc_pkg.sv
hdl/path_dot_segment_checker_top.sv
bench/tb_top.sv
